/* rtl/tls_pkg.sv */
// Package for the two-way traffic light sequencer.
// Types, phase codes, lamp codes and digit helpers shared by all files.
// No dependencies.
`timescale 1ns / 1ps

package tls_pkg;

    localparam int TICKS_PER_SECOND = 10;
    localparam int DIGIT_COUNT      = 4;

    localparam int SEC_W   = 7;   // configured seconds
    localparam int CNT_W   = 8;   // per-road countdown
    localparam int SHOW_W  = 7;   // countdown shown, saturated at SHOW_MAX
    localparam int DIV_W   = $clog2(TICKS_PER_SECOND + 1);
    localparam int TICKS_W = $clog2(((1 << SEC_W) - 1) * TICKS_PER_SECOND + 1);
    localparam int SCAN_W  = $clog2(DIGIT_COUNT);
    localparam int SHOW_MAX = 99;

    // Configuration register indexes
    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_RED   = 2'd1;
    localparam logic [1:0] CFG_GREEN = 2'd2;

    // Lamp codes
    typedef logic [1:0] t_lamp;
    localparam t_lamp LAMP_NONE  = 2'd0;
    localparam t_lamp LAMP_GREEN = 2'd1;
    localparam t_lamp LAMP_AMBER = 2'd2;
    localparam t_lamp LAMP_RED   = 2'd3;

    // Scan positions
    localparam logic [SCAN_W-1:0] SCAN_NS_TENS = SCAN_W'(0);
    localparam logic [SCAN_W-1:0] SCAN_NS_ONES = SCAN_W'(1);
    localparam logic [SCAN_W-1:0] SCAN_EW_TENS = SCAN_W'(2);
    localparam logic [SCAN_W-1:0] SCAN_EW_ONES = SCAN_W'(3);

    typedef enum logic [4:0] {
        PH_INIT     = 5'b00001,
        PH_NS_GREEN = 5'b00010,
        PH_NS_AMBER = 5'b00100,
        PH_EW_GREEN = 5'b01000,
        PH_EW_AMBER = 5'b10000
    } t_phase;

    typedef struct packed {
        logic             mode;
        logic [SEC_W-1:0] red;
        logic [SEC_W-1:0] green;
    } t_cfg;

    typedef struct packed {
        t_phase              phase;
        logic [TICKS_W-1:0]  ticks_left;
        logic [DIV_W-1:0]    divider;
        logic [CNT_W-1:0]    ns_count;
        logic [CNT_W-1:0]    ew_count;
        logic [SCAN_W-1:0]   scan;
    } t_state;

    typedef struct packed {
        t_lamp               ns_light;
        t_lamp               ew_light;
        logic [SHOW_W-1:0]   ns_remaining;
        logic [SHOW_W-1:0]   ew_remaining;
        logic [SCAN_W-1:0]   scan_position;
        logic [3:0]          scan_value;
    } t_result;

    function automatic logic [SEC_W-1:0] floor_sub(input logic [SEC_W-1:0] a,
                                                   input logic [SEC_W-1:0] b);
        return (a > b) ? SEC_W'(a - b) : '0;
    endfunction

    function automatic logic [TICKS_W-1:0] ticks_of(input logic [SEC_W-1:0] secs);
        return TICKS_W'(secs * TICKS_PER_SECOND);
    endfunction

    function automatic logic [SHOW_W-1:0] saturate(input logic [CNT_W-1:0] cnt);
        return (cnt > CNT_W'(SHOW_MAX)) ? SHOW_W'(SHOW_MAX) : cnt[SHOW_W-1:0];
    endfunction

    // Divide by ten through a reciprocal multiply; exact for 0..127
    function automatic logic [3:0] tens_of(input logic [SHOW_W-1:0] v);
        logic [14:0] prod;
        prod = 15'(v) * 15'd205;
        return prod[14:11];
    endfunction

    function automatic logic [3:0] ones_of(input logic [SHOW_W-1:0] v);
        logic [SHOW_W-1:0] t10;
        t10 = SHOW_W'(tens_of(v)) * SHOW_W'(10);
        return 4'(v - t10);
    endfunction

endpackage

/* rtl/tls_if.sv */
// Handshake channels of the traffic light sequencer: input item and result item.
// Depends on tls_pkg for field widths.
`timescale 1ns / 1ps

interface tls_in_if;
    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink   (input valid, input tick, output ready);
endinterface

interface tls_out_if;
    import tls_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        ns_light;
    logic [1:0]        ew_light;
    logic [SHOW_W-1:0] ns_remaining;
    logic [SHOW_W-1:0] ew_remaining;
    logic [1:0]        scan_position;
    logic [3:0]        scan_value;

    modport source (output valid, output ns_light, output ew_light, output ns_remaining,
                    output ew_remaining, output scan_position, output scan_value,
                    input ready);
    modport sink   (input valid, input ns_light, input ew_light, input ns_remaining,
                    input ew_remaining, input scan_position, input scan_value,
                    output ready);
endinterface

/* rtl/tls_step.sv */
// Next-state and result logic for one item of the traffic light sequencer.
// Depends on tls_pkg.
`timescale 1ns / 1ps

module tls_step
    import tls_pkg::*;
(
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    input  logic    i_tick,
    output t_state  o_state,
    output t_result o_result
);

    logic [SEC_W-1:0] amber;
    logic [SEC_W-1:0] len;
    logic [DIV_W-1:0] div_inc;
    logic             enter;
    t_phase           entry;
    t_state           nxt;

    always_comb begin
        amber   = i_cfg.mode ? floor_sub(i_cfg.green, i_cfg.red)
                             : floor_sub(i_cfg.red, i_cfg.green);
        nxt     = i_state;
        enter   = 1'b0;
        entry   = PH_NS_GREEN;
        div_inc = DIV_W'(i_state.divider + 1'b1);
        len     = '0;

        if (i_tick) begin
            if (i_state.phase == PH_INIT) begin
                enter       = 1'b1;
                nxt.divider = '0;
            end else begin
                // One second elapses: drop both countdowns, floored at zero
                if (div_inc >= DIV_W'(TICKS_PER_SECOND)) begin
                    nxt.divider = '0;
                    if (i_state.ns_count != '0) nxt.ns_count = i_state.ns_count - 1'b1;
                    if (i_state.ew_count != '0) nxt.ew_count = i_state.ew_count - 1'b1;
                end else begin
                    nxt.divider = div_inc;
                end
                if (i_state.ticks_left <= TICKS_W'(1)) begin
                    enter = 1'b1;
                    case (i_state.phase)
                        PH_NS_GREEN: entry = PH_NS_AMBER;
                        PH_NS_AMBER: entry = PH_EW_GREEN;
                        PH_EW_GREEN: entry = PH_EW_AMBER;
                        default:     entry = PH_NS_GREEN;
                    endcase
                end else begin
                    nxt.ticks_left = i_state.ticks_left - 1'b1;
                end
            end
            nxt.scan = (i_state.scan == SCAN_W'(DIGIT_COUNT - 1)) ? '0
                                                                 : i_state.scan + 1'b1;
        end

        // Load phase length and countdowns on a phase change
        if (enter) begin
            case (entry)
                PH_NS_GREEN: begin
                    len          = i_cfg.green;
                    nxt.ns_count = CNT_W'(i_cfg.green);
                    nxt.ew_count = i_cfg.mode ? CNT_W'(i_cfg.green) + CNT_W'(amber)
                                              : CNT_W'(i_cfg.red);
                end
                PH_NS_AMBER: begin
                    len          = amber;
                    nxt.ns_count = CNT_W'(amber);
                    if (!i_cfg.mode) nxt.ew_count = CNT_W'(amber);
                end
                PH_EW_GREEN: begin
                    len          = i_cfg.mode ? floor_sub(i_cfg.red, amber) : i_cfg.green;
                    nxt.ns_count = CNT_W'(i_cfg.red);
                    nxt.ew_count = CNT_W'(len);
                end
                default: begin
                    len          = amber;
                    nxt.ns_count = CNT_W'(amber);
                    nxt.ew_count = CNT_W'(amber);
                end
            endcase
            nxt.phase      = entry;
            nxt.ticks_left = ticks_of(len);
        end
    end

    always_comb begin
        o_state = nxt;
        o_result.scan_position = nxt.scan;
        o_result.ns_remaining  = saturate(nxt.ns_count);
        o_result.ew_remaining  = saturate(nxt.ew_count);
        case (nxt.phase)
            PH_NS_GREEN: begin
                o_result.ns_light = LAMP_GREEN; o_result.ew_light = LAMP_RED;
            end
            PH_NS_AMBER: begin
                o_result.ns_light = LAMP_AMBER; o_result.ew_light = LAMP_RED;
            end
            PH_EW_GREEN: begin
                o_result.ns_light = LAMP_RED;   o_result.ew_light = LAMP_GREEN;
            end
            PH_EW_AMBER: begin
                o_result.ns_light = LAMP_RED;   o_result.ew_light = LAMP_AMBER;
            end
            default: begin
                o_result.ns_light = LAMP_NONE;  o_result.ew_light = LAMP_NONE;
            end
        endcase
        case (nxt.scan)
            SCAN_NS_TENS: o_result.scan_value = tens_of(o_result.ns_remaining);
            SCAN_NS_ONES: o_result.scan_value = ones_of(o_result.ns_remaining);
            SCAN_EW_TENS: o_result.scan_value = tens_of(o_result.ew_remaining);
            default:      o_result.scan_value = ones_of(o_result.ew_remaining);
        endcase
    end

endmodule

/* rtl/two_way_traffic_light_sequencer.sv */
// Top level of the two-way traffic light sequencer.
// Depends on tls_pkg, tls_if (channels) and tls_step (next-state logic).
`timescale 1ns / 1ps

// Each input item carries one tick flag; a set flag advances the light one
// time-base tick (init, NS green, NS amber, EW green, EW amber, then NS green
// again), a clear flag only reports the current state. Every item yields one
// result item with both lamp codes, both countdowns saturated at 99 and the
// digit being scanned. The block takes one item per clock unless a waiting
// result is not taken: an item is held in the input register, the state
// update and the result are formed from it, and the result waits in the
// output register. An item passes through the input register and then the
// output register before its result can be taken. The input side keeps
// accepting while a result waits, as long as the input register can move
// forward. Phase lengths count TICKS_PER_SECOND ticks per second. The mode,
// red and green registers are read at each phase change.
module two_way_traffic_light_sequencer
    import tls_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    tls_in_if.sink            i_in,
    tls_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [SEC_W-1:0]  i_cfg_data
);

    logic    r_in_valid;
    logic    r_in_tick;
    logic    r_out_valid;
    t_result r_out;
    t_state  r_state;
    t_cfg    r_cfg;

    t_state  n_state;
    t_result n_out;
    logic    w_advance;

    // Move the held item forward when the result register is free or draining
    assign w_advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    tls_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_tick   (r_in_tick),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Configuration registers; writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode  <= 1'b0;
            r_cfg.red   <= SEC_W'(5);
            r_cfg.green <= SEC_W'(3);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:  r_cfg.mode  <= i_cfg_data[0];
                CFG_RED:   r_cfg.red   <= i_cfg_data;
                CFG_GREEN: r_cfg.green <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_tick <= i_in.tick;
        end
    end

    // Sequencer state: update only when an item is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= PH_INIT;
            r_state.ticks_left <= '0;
            r_state.divider    <= '0;
            r_state.ns_count   <= '0;
            r_state.ew_count   <= '0;
            r_state.scan       <= '0;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.ns_light      = r_out.ns_light;
    assign o_out.ew_light      = r_out.ew_light;
    assign o_out.ns_remaining  = r_out.ns_remaining;
    assign o_out.ew_remaining  = r_out.ew_remaining;
    assign o_out.scan_position = r_out.scan_position;
    assign o_out.scan_value    = r_out.scan_value;

    // State moves only when an item is processed
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_state))
        else $error("state changed without an item");

    // A tick in init always enters NS green
    a_init_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_tick && r_state.phase == PH_INIT)
            |=> r_state.phase == PH_NS_GREEN)
        else $error("init tick did not enter NS green");

    // A waiting result always shows the current scan position
    a_scan_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.scan_position == r_state.scan)
        else $error("result scan position out of step with state");

    // The second divider never reaches a full second
    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.divider < DIV_W'(TICKS_PER_SECOND))
        else $error("second divider out of range");

endmodule
